// File: src/csw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_pkg: shared types and constants of the counting semaphore
// Field widths, operation and status codes, sequencer states and the
// command word that drives the wait-slot store.
// ----------------------------------------------------------------------------
package csw_pkg;

  localparam int OP_W           = 2;
  localparam int ID_W           = 16;
  localparam int COUNT_W        = 16;
  localparam int STATUS_W       = 3;
  localparam int DEF_WAIT_SLOTS = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_TRY  = 2'd0,
    OP_WAIT = 2'd1,
    OP_POST = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_GRANTED = 3'd0,
    STS_REFUSED = 3'd1,
    STS_QUEUED  = 3'd2,
    STS_FULL    = 3'd3,
    STS_POSTED  = 3'd4,
    STS_WOKEN   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_PARK_SCAN,
    FSM_WAKE_SCAN,
    FSM_WAKE_EMIT
  } fsm_state_t;

  // Command word from the sequencer to the wait-slot store.
  typedef struct packed {
    logic clear_all;
    logic park;
    logic unpark;
    logic rd_en;
  } slot_cmd_t;

endpackage

// File: src/csw_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_ifs: request and result channels of the counting semaphore
// Valid/ready channels; a word moves on an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface csw_req_if
  import csw_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [ID_W-1:0] requester_id;

  modport source (output valid, output operation, output requester_id, input ready);
  modport sink   (input valid, input operation, input requester_id, output ready);
endinterface

interface csw_res_if
  import csw_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     woken_id;
  logic [COUNT_W-1:0]  count_after;
  logic                last;

  modport source (output valid, output status, output woken_id, output count_after,
                  output last, input ready);
  modport sink   (input valid, input status, input woken_id, input count_after,
                  input last, output ready);
endinterface

// File: src/counting_semaphore_wait_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_wait_list: counting semaphore with a wait list
// Try, wait and post requests against a 16-bit unit count, with parked ids
// released as a burst of wake words when a post brings the count to one.
// ----------------------------------------------------------------------------
// Each request word is taken in the idle state and decided in the exec
// state, after which a try, a granted wait, a refused request or a post
// that wakes nobody returns to idle. A wait that has to park walks the slot
// valid bits one slot per cycle until it finds the first free slot. A waking
// post walks every slot up to the last occupied one, one per cycle over empty
// slots, reads each woken id through the registered memory read and waits in
// the emit state while the result side stalls. The request side is not ready
// while a request is in work; a stalled result side holds the sequencer only
// when it has a word to hand over. Writing cfg_wdata with cfg_we loads the
// count and empties the wait list; reset does the same with a count of zero.
// Write the register only when the block is idle.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_list
  import csw_pkg::*;
#(
  parameter int WAIT_SLOTS = DEF_WAIT_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  csw_req_if.sink            in_req,
  csw_res_if.source          out_res,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  localparam int IDX_W = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
  localparam int OCC_W = $clog2(WAIT_SLOTS + 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(WAIT_SLOTS);
  localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);

  // Sequencer state and the latched request.
  fsm_state_t         state_r, state_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;

  // Semaphore count, number of occupied slots and the slot scan index.
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  // Output register; it parts the sequencer from the result handshake.
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ID_W-1:0]     out_woken_r, out_woken_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                out_last_r, out_last_nxt;

  // Result word the sequencer hands to the output register this cycle.
  logic                emit;
  status_t             emit_status;
  logic [ID_W-1:0]     emit_woken;
  logic                emit_last;

  logic                out_free;
  logic [COUNT_W-1:0]  count_inc;
  slot_cmd_t           slot_cmd;
  logic [WAIT_SLOTS-1:0] slot_valid;
  logic [ID_W-1:0]     slot_rd_data;

  csw_slot_store #(
    .WAIT_SLOTS (WAIT_SLOTS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (slot_cmd),
    .idx     (idx_r),
    .wdata   (id_r),
    .valid   (slot_valid),
    .rd_data (slot_rd_data)
  );

  // A new result word may be loaded when the register is empty or being taken.
  assign out_free  = !out_valid_r || out_res.ready;
  // Post saturates at the top of the count range.
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;

  assign in_req.ready = (state_r == FSM_IDLE);

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    id_nxt      = id_r;
    count_nxt   = count_r;
    occ_nxt     = occ_r;
    idx_nxt     = idx_r;
    emit        = 1'b0;
    emit_status = STS_REFUSED;
    emit_woken  = '0;
    emit_last   = 1'b1;
    slot_cmd    = '0;

    case (state_r)
      FSM_IDLE: begin
        if (in_req.valid) begin
          op_nxt    = in_req.operation;
          id_nxt    = in_req.requester_id;
          state_nxt = FSM_EXEC;
        end
      end

      FSM_EXEC: begin
        case (op_r)
          OP_TRY: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = FSM_IDLE;
              if (count_r != '0) begin
                count_nxt   = count_r - 1'b1;
                emit_status = STS_GRANTED;
              end else begin
                emit_status = STS_REFUSED;
              end
            end
          end
          OP_WAIT: begin
            if (count_r != '0) begin
              if (out_free) begin
                emit        = 1'b1;
                emit_status = STS_GRANTED;
                count_nxt   = count_r - 1'b1;
                state_nxt   = FSM_IDLE;
              end
            end else if (occ_r == OCC_FULL) begin
              if (out_free) begin
                emit        = 1'b1;
                emit_status = STS_FULL;
                state_nxt   = FSM_IDLE;
              end
            end else begin
              idx_nxt   = '0;
              state_nxt = FSM_PARK_SCAN;
            end
          end
          OP_POST: begin
            if (count_inc == COUNT_W'(1) && occ_r != '0) begin
              // The count just became one: release every parked id.
              count_nxt = count_inc;
              idx_nxt   = '0;
              state_nxt = FSM_WAKE_SCAN;
            end else if (out_free) begin
              count_nxt   = count_inc;
              emit        = 1'b1;
              emit_status = STS_POSTED;
              state_nxt   = FSM_IDLE;
            end
          end
          default: begin
            // The unused operation code is refused and changes nothing.
            if (out_free) begin
              emit        = 1'b1;
              emit_status = STS_REFUSED;
              state_nxt   = FSM_IDLE;
            end
          end
        endcase
      end

      FSM_PARK_SCAN: begin
        // A free slot exists because the list was found not full.
        if (!slot_valid[idx_r]) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = STS_QUEUED;
            state_nxt   = FSM_IDLE;
            // A zero id answers queued but leaves the slot empty.
            if (id_r != '0) begin
              slot_cmd.park = 1'b1;
              occ_nxt       = occ_r + 1'b1;
            end
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      FSM_WAKE_SCAN: begin
        if (slot_valid[idx_r]) begin
          slot_cmd.rd_en = 1'b1;
          state_nxt      = FSM_WAKE_EMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      FSM_WAKE_EMIT: begin
        if (out_free) begin
          emit            = 1'b1;
          emit_status     = STS_WOKEN;
          emit_woken      = slot_rd_data;
          emit_last       = (occ_r == OCC_ONE);
          slot_cmd.unpark = 1'b1;
          occ_nxt         = occ_r - 1'b1;
          if (occ_r == OCC_ONE) begin
            state_nxt = FSM_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = FSM_WAKE_SCAN;
          end
        end
      end

      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase

    // A configuration write reloads the count and empties the list.
    slot_cmd.clear_all = cfg_we;

    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_woken_nxt  = out_woken_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = emit_status;
      out_woken_nxt  = emit_woken;
      out_count_nxt  = count_nxt;
      out_last_nxt   = emit_last;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
        occ_r   <= '0;
      end else begin
        count_r <= count_nxt;
        occ_r   <= occ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_woken_r  <= out_woken_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.status      = out_status_r;
  assign out_res.woken_id    = out_woken_r;
  assign out_res.count_after = out_count_r;
  assign out_res.last        = out_last_r;

endmodule

// File: src/csw_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_slot_store: wait-slot memory with per-slot valid bits
// Parked ids live in a small memory; a valid flag per slot marks it occupied,
// so clearing the list only clears the flags. Read data is registered.
// ----------------------------------------------------------------------------
module csw_slot_store
  import csw_pkg::*;
#(
  parameter int WAIT_SLOTS = DEF_WAIT_SLOTS,
  parameter int IDX_W      = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  slot_cmd_t             cmd,
  input  logic [IDX_W-1:0]      idx,
  input  logic [ID_W-1:0]       wdata,
  output logic [WAIT_SLOTS-1:0] valid,
  output logic [ID_W-1:0]       rd_data
);

  logic [ID_W-1:0]       mem [WAIT_SLOTS];
  logic [WAIT_SLOTS-1:0] valid_r;
  logic [ID_W-1:0]       rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all) begin
      valid_r <= '0;
    end else if (cmd.park) begin
      valid_r[idx] <= 1'b1;
    end else if (cmd.unpark) begin
      valid_r[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.park) begin
      mem[idx] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[idx];
    end
  end

  assign valid   = valid_r;
  assign rd_data = rd_data_r;

endmodule

// File: src/csw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_checker: port-level assertions for the counting semaphore
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module csw_checker
  import csw_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [ID_W-1:0]     out_woken_id,
  input logic [COUNT_W-1:0]  out_count_after,
  input logic                out_last
);

  // One request is in work at a time, so ready drops after every accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a request was still in work");

  // The woken id field is nonzero exactly on wake words.
  a_woken_id_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == STS_WOKEN) == (out_woken_id != '0)))
    else $error("woken id does not match the status");

  // Wakes happen only when a post has brought the count to one.
  a_wake_count_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_WOKEN |-> out_count_after == COUNT_W'(1))
    else $error("wake word with a count other than one");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_woken_id) && $stable(out_count_after) && $stable(out_last))
    else $error("result word changed while stalled");

endmodule

bind counting_semaphore_wait_list csw_checker u_csw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .out_status      (out_res.status),
  .out_woken_id    (out_res.woken_id),
  .out_count_after (out_res.count_after),
  .out_last        (out_res.last)
);

// File: bench/csw_semaphore_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_semaphore_checker: result predictor and scoreboard for the semaphore
// Watches the request, result and register ports and keeps its own copy of
// the unit count and the wait list. Compares each result word in order.
// ----------------------------------------------------------------------------
module csw_semaphore_checker
  import csw_pkg::*;
#(
  parameter int WAIT_SLOTS = DEF_WAIT_SLOTS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  input  logic                req_ready,
  input  logic [OP_W-1:0]     req_operation,
  input  logic [ID_W-1:0]     req_requester_id,
  input  logic                res_valid,
  input  logic                res_ready,
  input  logic [STATUS_W-1:0] res_status,
  input  logic [ID_W-1:0]     res_woken_id,
  input  logic [COUNT_W-1:0]  res_count_after,
  input  logic                res_last,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_wdata,
  output int                  fail_count,
  output int                  pending_words
);

  typedef struct {
    status_t            status;
    logic [ID_W-1:0]    woken_id;
    logic [COUNT_W-1:0] count_after;
    logic               last;
  } result_word_t;

  logic [COUNT_W-1:0] model_units;
  logic [ID_W-1:0]    parked_ids [WAIT_SLOTS];
  result_word_t       awaited_words [$];
  int                 failures = 0;

  function automatic void clear_wait_list();
    for (int i = 0; i < WAIT_SLOTS; i++) parked_ids[i] = '0;
  endfunction

  function automatic void await_word(status_t status, logic [ID_W-1:0] id, logic last);
    result_word_t w;
    w.status      = status;
    w.woken_id    = id;
    w.count_after = model_units;
    w.last        = last;
    awaited_words.push_back(w);
  endfunction

  // Works out the result words of one accepted request and updates the state.
  function automatic void apply_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
    int           free_slot;
    int           woken;
    result_word_t tail;
    free_slot = -1;
    woken     = 0;
    case (op)
      OP_TRY: begin
        if (model_units != '0) begin
          model_units = model_units - 1'b1;
          await_word(STS_GRANTED, '0, 1'b1);
        end else begin
          await_word(STS_REFUSED, '0, 1'b1);
        end
      end
      OP_WAIT: begin
        if (model_units != '0) begin
          model_units = model_units - 1'b1;
          await_word(STS_GRANTED, '0, 1'b1);
        end else begin
          for (int i = WAIT_SLOTS - 1; i >= 0; i--)
            if (parked_ids[i] == '0) free_slot = i;
          if (free_slot < 0) begin
            await_word(STS_FULL, '0, 1'b1);
          end else begin
            // An id of zero leaves the slot looking empty.
            parked_ids[free_slot] = id;
            await_word(STS_QUEUED, '0, 1'b1);
          end
        end
      end
      OP_POST: begin
        if (model_units != COUNT_MAX) model_units = model_units + 1'b1;
        if (model_units == 1) begin
          for (int i = 0; i < WAIT_SLOTS; i++) begin
            if (parked_ids[i] != '0) begin
              await_word(STS_WOKEN, parked_ids[i], 1'b0);
              parked_ids[i] = '0;
              woken++;
            end
          end
        end
        if (woken == 0) begin
          await_word(STS_POSTED, '0, 1'b1);
        end else begin
          tail      = awaited_words.pop_back();
          tail.last = 1'b1;
          awaited_words.push_back(tail);
        end
      end
      default: await_word(STS_REFUSED, '0, 1'b1);
    endcase
  endfunction

  function automatic void check_word();
    result_word_t want;
    if (awaited_words.size() == 0) begin
      $display("%0t: result word with none expected: status=%0d woken_id=%h count_after=%0d last=%b",
               $time, res_status, res_woken_id, res_count_after, res_last);
      failures++;
    end else begin
      want = awaited_words.pop_front();
      if (want.status != res_status || want.woken_id != res_woken_id ||
          want.count_after != res_count_after || want.last != res_last) begin
        $display("%0t: result word mismatch: expected status=%s woken_id=%h count_after=%0d last=%b",
                 $time, want.status.name(), want.woken_id, want.count_after, want.last);
        $display("%0t:                       actual   status=%0d woken_id=%h count_after=%0d last=%b",
                 $time, res_status, res_woken_id, res_count_after, res_last);
        failures++;
      end
    end
  endfunction

  // Results are checked before the new request is predicted, so a word can
  // never be matched against an expectation from the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      model_units = '0;
      clear_wait_list();
      awaited_words.delete();
    end else begin
      if (cfg_we) begin
        model_units = cfg_wdata;
        clear_wait_list();
      end
      if (res_valid && res_ready) check_word();
      if (req_valid && req_ready) apply_request(req_operation, req_requester_id);
    end
    fail_count    <= failures;
    pending_words <= awaited_words.size();
  end

endmodule

// File: bench/counting_semaphore_wait_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_wait_list_tb: testbench of the counting semaphore
// Drives try, wait and post requests under several loaded counts, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_list_tb;
  import csw_pkg::*;

  // The package has no name for the fourth operation code; the block must
  // refuse it and leave its state alone.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // The register is written only after this many quiet cycles past the
  // last result word.
  localparam int SETTLE_CYCLES = DEF_WAIT_SLOTS + 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int IDLE_PERCENT  = 29;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;
  logic               sink_ready = 1'b0;
  logic               steady = 1'b0;
  int                 fail_count;
  int                 pending_words;
  int                 cycles = 0;

  csw_req_if req_if ();
  csw_res_if res_if ();

  assign res_if.ready = sink_ready;

  counting_semaphore_wait_list i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_if),
    .out_res   (res_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  csw_semaphore_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req_if.valid),
    .req_ready        (req_if.ready),
    .req_operation    (req_if.operation),
    .req_requester_id (req_if.requester_id),
    .res_valid        (res_if.valid),
    .res_ready        (res_if.ready),
    .res_status       (res_if.status),
    .res_woken_id     (res_if.woken_id),
    .res_count_after  (res_if.count_after),
    .res_last         (res_if.last),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending_words    (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The result side stalls at random, except while the steady stretch runs.
  always @(posedge clk) begin
    sink_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Watchdog: a hung handshake or a lost word ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("counting_semaphore_wait_list_tb: done, errors");
      $finish;
    end
  end

  // Offers one request word and returns at the edge that accepts it. The
  // valid line is only lowered when a gap is inserted, so back-to-back words
  // keep it high without a second assignment in the same step.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.operation    <= op;
    req_if.requester_id <= id;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // Holds the request side quiet until every predicted word has arrived.
  task automatic wait_for_results(input int settle);
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Loading the count also empties the wait list, so the block must be idle.
  task automatic load_initial_count(input logic [COUNT_W-1:0] value);
    wait_for_results(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly nonzero ids; now and then a zero id, which queues but never parks.
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(19) == 0) return '0;
    return ID_W'($urandom_range(65535, 1));
  endfunction

  initial begin
    logic [COUNT_W-1:0] start_count;
    logic [OP_W-1:0]    op;
    int                 roll;
    int                 phase_words;
    int                 sent;

    req_if.valid        <= 1'b0;
    req_if.operation    <= OP_TRY;
    req_if.requester_id <= '0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, starting from the count of zero that reset leaves.
    // A try and the unused code are both refused with nothing to take.
    send_request(OP_TRY, 16'h0001);
    send_request(OP_UNUSED, 16'hFFFF);
    // Fill the list: the zero id answers queued without taking a slot, so it
    // takes eighteen waits to park sixteen ids and then hit a full list.
    for (int k = 0; k < 18; k++) begin
      if (k == 0)
        send_request(OP_WAIT, 16'hFFFF);
      else if (k == 1)
        send_request(OP_WAIT, 16'h0000);
      else
        send_request(OP_WAIT, 16'h5A00 + ID_W'(k));
    end
    // The post that brings the count to one wakes all sixteen parked ids.
    send_request(OP_POST, 16'h1234);
    send_request(OP_POST, 16'h1234);
    send_request(OP_TRY, 16'h0002);
    send_request(OP_WAIT, 16'h0003);
    // Count back at one with an empty list: a plain posted word.
    send_request(OP_POST, 16'h0004);

    // Saturation just below and at the top of the count.
    load_initial_count(16'hFFFE);
    send_request(OP_POST, 16'h0005);
    send_request(OP_POST, 16'h0006);
    send_request(OP_TRY, 16'h0007);

    // Random part: phases under different loaded counts. Low counts keep
    // the list busy, so they get most of the words.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: start_count = '0;
        1: start_count = 16'd1;
        2: start_count = COUNT_MAX;
        3: start_count = 16'd2;
        4: start_count = COUNT_W'($urandom_range(7));
        5: start_count = COUNT_MAX - 1'b1;
        6: start_count = COUNT_W'($urandom_range(65535));
        default: start_count = '0;
      endcase
      load_initial_count(start_count);
      // One phase runs with neither side idling.
      steady      <= (phase == 3);
      phase_words = (start_count > 16'd100) ? 20 : 65;
      sent        = 0;
      while (sent < phase_words) begin
        roll = $urandom_range(99);
        if (roll < 6) begin
          // A burst of waits drives the list towards full.
          for (int k = $urandom_range(20, 8); k > 0; k--) begin
            send_request(OP_WAIT, pick_id());
            sent++;
          end
        end else begin
          if (roll < 45)
            op = OP_WAIT;
          else if (roll < 75)
            op = OP_POST;
          else if (roll < 95)
            op = OP_TRY;
          else
            op = OP_UNUSED;
          send_request(op, pick_id());
          sent++;
        end
        // Now and then the sender holds off until the block has drained.
        if ($urandom_range(39) == 0) wait_for_results(0);
      end
    end

    wait_for_results(SETTLE_CYCLES);
    if (fail_count == 0 && pending_words == 0)
      $display("counting_semaphore_wait_list_tb: done, clean");
    else
      $display("counting_semaphore_wait_list_tb: done, errors");
    $finish;
  end

endmodule
